@@ rtl/grc_pkg.sv @@
// grc_pkg: shared constants, ray record and sine table for the column raycaster
// depends on nothing; imported by every rtl module of grid_raycast_column
package grc_pkg;

    localparam int MAP_SIZE   = 16;
    localparam int VIEW_DEPTH = 16;
    localparam int LIMIT      = VIEW_DEPTH * 10;
    localparam int NW         = $clog2(LIMIT + 1);
    localparam int QTR        = 1024;
    localparam int SINW       = 15;
    localparam int DQW        = 13;
    localparam int QMAX       = 16384 * 2 * LIMIT / 5;
    localparam int QW         = $clog2(QMAX + 1);
    localparam int PW         = ((QW > 20) ? QW : 20) + 2;
    localparam int NUMW       = $clog2(63 * LIMIT + 1);
    localparam int DW         = NW + 1;
    localparam int QDEPTH     = 2;

    localparam int REG_MAP0   = 0;
    localparam int REG_MAP1   = 1;
    localparam int REG_MAP2   = 2;
    localparam int REG_MAP3   = 3;
    localparam int REG_WIDTH  = 4;
    localparam int REG_HEIGHT = 5;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic [3:0]     px;
        logic [3:0]     py;
        logic           negx;
        logic           negy;
        logic [DQW-1:0] dqx;
        logic [DQW-1:0] dqy;
        logic [2:0]     drx;
        logic [2:0]     dry;
    } t_ray;

    typedef logic [SINW-1:0] t_qsin_tab [0:QTR];

    function automatic logic [SINW-1:0] quarter_sin(input longint unsigned a);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        x  = (a * PI_Q30) / 2048;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384) q = 64'd16384;
        return q[SINW-1:0];
    endfunction

    function automatic t_qsin_tab gen_qsin();
        t_qsin_tab tab;
        for (int i = 0; i <= QTR; i++) begin
            tab[i] = quarter_sin(longint'(i));
        end
        return tab;
    endfunction

    localparam t_qsin_tab QSIN_TAB = gen_qsin();

endpackage

@@ rtl/grid_raycast_column.sv @@
// grid_raycast_column: top level, register port, front, ray queue and back
// depends on grc_pkg, grc_front, grc_queue, grc_back
//
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_player_col i_player_row i_heading i_column
// output    out        o_valid / i_stall   o_hit_steps o_ceiling_row o_floor_row o_shade
// config    in         psel penable pwrite paddr pwdata -> prdata pready
//
// front: per transaction an angle division, two table reads and a queue push; input stalls until then
// back: pop, then one march cycle per 0.1-cell step up to the wall or map edge, then
// product, row division and output load
// for long marches the sustained rate is set by the back march loop, one 0.1-cell step per cycle
// synchronous active-low reset empties the queue and restores register defaults
// a stalled output holds the result while the front keeps filling the queue
module grid_raycast_column (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_player_col,
    input  logic [3:0]  i_player_row,
    input  logic [2:0]  i_heading,
    input  logic [7:0]  i_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_hit_steps,
    output logic signed [10:0] o_ceiling_row,
    output logic [9:0]  o_floor_row,
    output logic [1:0]  o_shade,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import grc_pkg::*;

    logic [255:0] r_map;
    logic [7:0]   r_vw;
    logic [5:0]   r_vh;
    logic [2:0]   n_idx;
    logic         n_wr;
    logic         q_full, q_empty, q_push, q_pop;
    t_ray         q_in, q_out;

    assign pready = 1'b1;
    assign n_idx  = paddr[5:3];
    assign n_wr   = psel && penable && pwrite;

    always_comb begin
        unique case (n_idx)
            3'(REG_MAP0):   prdata = r_map[63:0];
            3'(REG_MAP1):   prdata = r_map[127:64];
            3'(REG_MAP2):   prdata = r_map[191:128];
            3'(REG_MAP3):   prdata = r_map[255:192];
            3'(REG_WIDTH):  prdata = {56'd0, r_vw};
            3'(REG_HEIGHT): prdata = {58'd0, r_vh};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
            r_vw  <= 8'd120;
            r_vh  <= 6'd40;
        end else if (n_wr) begin
            unique case (n_idx)
                3'(REG_MAP0):   r_map[63:0]    <= pwdata;
                3'(REG_MAP1):   r_map[127:64]  <= pwdata;
                3'(REG_MAP2):   r_map[191:128] <= pwdata;
                3'(REG_MAP3):   r_map[255:192] <= pwdata;
                3'(REG_WIDTH):  r_vw <= pwdata[7:0];
                3'(REG_HEIGHT): r_vh <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    grc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_player_col(i_player_col), .i_player_row(i_player_row),
        .i_heading(i_heading), .i_column(i_column),
        .i_view_width(r_vw),
        .i_q_full(q_full), .o_q_push(q_push), .o_q_data(q_in)
    );

    grc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_out), .o_empty(q_empty)
    );

    grc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .i_q_data(q_out), .o_q_pop(q_pop),
        .i_map(r_map), .i_view_height(r_vh),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit_steps(o_hit_steps), .o_ceiling_row(o_ceiling_row),
        .o_floor_row(o_floor_row), .o_shade(o_shade)
    );

endmodule

@@ rtl/grc_queue.sv @@
// grc_queue: short ray queue between front and back
// depends on grc_pkg (t_ray, QDEPTH)
module grc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  grc_pkg::t_ray i_data,
    output logic          o_full,
    input  logic          i_pop,
    output grc_pkg::t_ray o_data,
    output logic          o_empty
);
    import grc_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_ray            r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= r_wp + 1'b1;
            end
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full ray queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty ray queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty) else $error("queue lost an entry");

endmodule

@@ rtl/grc_front.sv @@
// grc_front: accepts column transactions, forms ray angle and per-step increments
// depends on grc_pkg (sine table, t_ray)
module grc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [3:0]    i_player_col,
    input  logic [3:0]    i_player_row,
    input  logic [2:0]    i_heading,
    input  logic [7:0]    i_column,
    input  logic [7:0]    i_view_width,
    input  logic          i_q_full,
    output logic          o_q_push,
    output grc_pkg::t_ray o_q_data
);
    import grc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ANG, S_SIN, S_COS, S_FIN, S_PUSH} t_state;

    t_state          r_state;
    logic [3:0]      r_px, r_py;
    logic [2:0]      r_head;
    logic [16:0]     r_quo;
    logic [7:0]      r_rem;
    logic [4:0]      r_cnt;
    logic [11:0]     r_ang;
    logic [SINW-1:0] r_rom, r_ex, r_ey;

    logic [8:0]      n_t;
    logic            n_ge;
    logic [11:0]     n_ang, n_cang, n_sel;
    logic [10:0]     n_idx;
    logic [15:0]     n_dx, n_dy;
    logic [33:0]     n_mx, n_my;
    logic [DQW-1:0]  n_qx, n_qy;
    logic [15:0]     n_rx, n_ry;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_t  = {r_rem, r_quo[16]};
        n_ge = (n_t >= {1'b0, i_view_width});
        n_ang = {r_head, 9'd0} + 12'd3840 +
                ((i_view_width == 8'd0) ? 12'd0 : r_quo[11:0]);
        n_cang = r_ang + 12'd1024;
        n_sel  = (r_state == S_SIN) ? r_ang : n_cang;
        n_idx  = n_sel[10] ? (11'd1024 - {1'b0, n_sel[9:0]}) : {1'b0, n_sel[9:0]};
        n_dx = {r_ex, 1'b0};
        n_dy = {r_ey, 1'b0};
        n_mx = n_dx * 18'd52429;
        n_my = n_dy * 18'd52429;
        n_qx = n_mx[18 +: DQW];
        n_qy = n_my[18 +: DQW];
        n_rx = n_dx - {n_qx, 2'b00} - 16'(n_qx);
        n_ry = n_dy - {n_qy, 2'b00} - 16'(n_qy);
        o_q_data.px   = r_px;
        o_q_data.py   = r_py;
        o_q_data.negx = r_ang[11];
        o_q_data.negy = n_cang[11];
        o_q_data.dqx  = n_qx;
        o_q_data.dqy  = n_qy;
        o_q_data.drx  = n_rx[2:0];
        o_q_data.dry  = n_ry[2:0];
        o_q_push = (r_state == S_PUSH) && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        r_rom <= QSIN_TAB[n_idx];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px    <= i_player_col;
                        r_py    <= i_player_row;
                        r_head  <= i_heading;
                        r_quo   <= {i_column, 9'd0};
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_ge ? 8'(n_t - {1'b0, i_view_width}) : n_t[7:0];
                    r_quo <= {r_quo[15:0], n_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) r_state <= S_ANG;
                end
                S_ANG: begin
                    r_ang   <= n_ang;
                    r_state <= S_SIN;
                end
                S_SIN: r_state <= S_COS;
                S_COS: begin
                    r_ex    <= r_rom;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_ey    <= r_rom;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/grc_back.sv @@
// grc_back: marches each queued ray over the wall map, divides for the wall rows
// depends on grc_pkg (t_ray, LIMIT and width constants)
module grc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  grc_pkg::t_ray i_q_data,
    output logic          o_q_pop,
    input  logic [255:0]  i_map,
    input  logic [5:0]    i_view_height,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_hit_steps,
    output logic [10:0]   o_ceiling_row,
    output logic [9:0]    o_floor_row,
    output logic [1:0]    o_shade
);
    import grc_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_MARCH, B_MUL, B_DIV, B_OUT} t_state;

    t_state             r_state;
    t_ray               r_ray;
    logic [QW-1:0]      r_qx, r_qy;
    logic [2:0]         r_rx, r_ry;
    logic [NW-1:0]      r_n;
    logic [NUMW-1:0]    r_quo;
    logic [DW-1:0]      r_rem, r_den;
    logic               r_neg;
    logic [$clog2(NUMW)-1:0] r_cnt;
    logic               r_oval;
    logic [7:0]         r_steps;
    logic [10:0]        r_ceil;
    logic [9:0]         r_floor;
    logic [1:0]         r_shade;

    logic [3:0]         n_rx4, n_ry4;
    logic               n_cx, n_cy;
    logic [QW-1:0]      n_qx, n_qy;
    logic signed [PW-1:0] n_posx, n_posy, n_offx, n_offy, n_mx, n_my;
    logic               n_inx, n_iny, n_wall;
    logic [3:0]         n_cellx, n_celly;
    logic [NW-1:0]      n_nn, n_ad;
    logic [DW:0]        n_t;
    logic               n_ge;
    logic [10:0]        n_ceil;
    logic               n_load;

    assign o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_valid     = r_oval;
    assign o_hit_steps = r_steps;
    assign o_ceiling_row = r_ceil;
    assign o_floor_row = r_floor;
    assign o_shade     = r_shade;

    always_comb begin
        n_rx4 = {1'b0, r_rx} + {1'b0, r_ray.drx};
        n_ry4 = {1'b0, r_ry} + {1'b0, r_ray.dry};
        n_cx  = (n_rx4 >= 4'd5);
        n_cy  = (n_ry4 >= 4'd5);
        n_qx  = r_qx + QW'(r_ray.dqx) + QW'(n_cx);
        n_qy  = r_qy + QW'(r_ray.dqy) + QW'(n_cy);
        n_offx = r_ray.negx ? -$signed(PW'(n_qx)) : $signed(PW'(n_qx));
        n_offy = r_ray.negy ? -$signed(PW'(n_qy)) : $signed(PW'(n_qy));
        n_posx = $signed(PW'({r_ray.px, 16'd0})) + n_offx;
        n_posy = $signed(PW'({r_ray.py, 16'd0})) + n_offy;
        n_mx  = -n_posx;
        n_my  = -n_posy;
        n_inx = n_posx[PW-1] ? (n_mx < $signed(PW'(65536))) :
                               (n_posx < $signed(PW'(1048576)));
        n_iny = n_posy[PW-1] ? (n_my < $signed(PW'(65536))) :
                               (n_posy < $signed(PW'(1048576)));
        n_cellx = n_posx[PW-1] ? 4'd0 : n_posx[19:16];
        n_celly = n_posy[PW-1] ? 4'd0 : n_posy[19:16];
        n_wall  = i_map[{n_celly, n_cellx}];
        n_nn    = r_n + 1'b1;
        n_ad    = (r_n >= NW'(20)) ? (r_n - NW'(20)) : (NW'(20) - r_n);
        n_t     = {r_rem, r_quo[NUMW-1]};
        n_ge    = (n_t >= {1'b0, r_den});
        n_ceil  = r_neg ? -11'(r_quo) : 11'(r_quo);
        n_load  = (r_state == B_OUT) && (!r_oval || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && !i_stall && !n_load) r_oval <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_ray   <= i_q_data;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_n     <= '0;
                        r_state <= B_MARCH;
                    end
                end
                B_MARCH: begin
                    r_qx <= n_qx;
                    r_qy <= n_qy;
                    r_rx <= n_cx ? 3'(n_rx4 - 4'd5) : n_rx4[2:0];
                    r_ry <= n_cy ? 3'(n_ry4 - 4'd5) : n_ry4[2:0];
                    priority if (!(n_inx && n_iny)) begin
                        r_n     <= NW'(LIMIT);
                        r_state <= B_MUL;
                    end else if (n_wall || n_nn == NW'(LIMIT)) begin
                        r_n     <= n_nn;
                        r_state <= B_MUL;
                    end else begin
                        r_n <= n_nn;
                    end
                end
                B_MUL: begin
                    r_quo   <= NUMW'(i_view_height) * NUMW'(n_ad);
                    r_neg   <= (r_n < NW'(20));
                    r_den   <= {r_n, 1'b0};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem <= n_ge ? DW'(n_t - {1'b0, r_den}) : n_t[DW-1:0];
                    r_quo <= {r_quo[NUMW-2:0], n_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ($clog2(NUMW))'(NUMW-1)) r_state <= B_OUT;
                end
                B_OUT: begin
                    if (n_load) begin
                        r_oval  <= 1'b1;
                        r_steps <= 8'(r_n);
                        r_ceil  <= n_ceil;
                        r_floor <= 10'({5'd0, i_view_height} - n_ceil);
                        if ((NW+2)'(r_n) * 3 < (NW+2)'(LIMIT))      r_shade <= 2'd0;
                        else if ((NW+2)'(r_n) * 2 < (NW+2)'(LIMIT)) r_shade <= 2'd1;
                        else if (r_n < NW'(LIMIT))                  r_shade <= 2'd2;
                        else                                        r_shade <= 2'd3;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_steps != 8'd0)) else $error("zero step count delivered");
    a_march_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MARCH) |-> (r_n < NW'(LIMIT))) else $error("march ran past depth");
    a_full_depth_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_shade != 2'd3) |-> (o_hit_steps < 8'(LIMIT)))
        else $error("shade disagrees with step count");

endmodule

@@ verif/grid_raycast_column_tb.sv @@
// grid_raycast_column_tb: self-checking bench for the column raycaster
// depends on grc_pkg and grid_raycast_column; predicts each column and checks results in order
module grid_raycast_column_tb;
    import grc_pkg::*;

    typedef struct {
        logic [3:0] col;
        logic [3:0] row;
        logic [2:0] heading;
        logic [7:0] column;
    } t_ray_req;

    typedef struct {
        logic [7:0]         steps;
        logic signed [10:0] ceil_row;
        logic [9:0]         floor_row;
        logic [1:0]         shade;
    } t_column;

    localparam int TIMEOUT_CYCLES = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_player_col;
    logic [3:0]  i_player_row;
    logic [2:0]  i_heading;
    logic [7:0]  i_column;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_hit_steps;
    logic signed [10:0] o_ceiling_row;
    logic [9:0]  o_floor_row;
    logic [1:0]  o_shade;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    grid_raycast_column DUT (.*);

    logic [63:0] wall_rows [0:3];
    int unsigned cur_width;
    int unsigned cur_height;

    t_ray_req pending_rays [$];
    t_column  expected_columns [$];
    int       mismatches;
    int       cycles;
    int       gap_left;
    int       stall_left;
    bit       feed_hold;
    bit       in_taken;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("grid_raycast_column_tb: FAIL");
            $finish;
        end
    end

    function automatic longint quarter_wave(input longint unsigned a);
        longint unsigned x, x2, t, s, q;
        x  = (a * 64'd3373259426) / 2048;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384) q = 16384;
        return longint'(q);
    endfunction

    function automatic longint sine_q14(input int unsigned ang);
        int unsigned a, r, quad;
        longint v;
        a = ang & 4095;
        r = a & 1023;
        quad = a >> 10;
        v = (quad & 1) ? quarter_wave(1024 - r) : quarter_wave(r);
        return (quad & 2) ? -v : v;
    endfunction

    function automatic longint cell_of(input longint pos);
        return (pos >= 0) ? (pos >>> 16) : -((-pos) >>> 16);
    endfunction

    function automatic t_column cast_column(input t_ray_req rq);
        t_column res;
        int unsigned frac, ang, y, x;
        longint ex, ey, n, cx, cy, lim, h, cr, fr;
        bit done;
        lim = VIEW_DEPTH * 10;
        frac = cur_width ? (int'(rq.column) * 512) / cur_width : 0;
        ang = (int'(rq.heading) * 512 + 4096 - 256 + frac) & 4095;
        ex = sine_q14(ang);
        ey = sine_q14(ang + 1024);
        n = 0;
        done = 0;
        while (!done && n < lim) begin
            n++;
            cx = cell_of((longint'(rq.col) <<< 16) + (ex * n * 2) / 5);
            cy = cell_of((longint'(rq.row) <<< 16) + (ey * n * 2) / 5);
            if (cx < 0 || cx >= MAP_SIZE || cy < 0 || cy >= MAP_SIZE) begin
                done = 1;
                n = lim;
            end else begin
                y = cy;
                x = cx;
                if (wall_rows[y >> 2][(y & 3) * 16 + x]) done = 1;
            end
        end
        if (n < 1) n = 1;
        h = cur_height;
        cr = (h * (n - 20)) / (2 * n);
        fr = h - cr;
        res.steps = n[7:0];
        res.ceil_row = cr[10:0];
        res.floor_row = fr[9:0];
        if (n * 3 < lim) res.shade = 0;
        else if (n * 2 < lim) res.shade = 1;
        else if (n < lim) res.shade = 2;
        else res.shade = 3;
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || in_taken) begin
            in_taken = 0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 0;
            end else if (pending_rays.size() > 0 && !feed_hold) begin
                t_ray_req rq;
                rq = pending_rays[0];
                i_valid <= 1;
                i_player_col <= rq.col;
                i_player_row <= rq.row;
                i_heading <= rq.heading;
                i_column <= rq.column;
                gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_column exp_col;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_columns.push_back(cast_column(pending_rays.pop_front()));
            in_taken = 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_columns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction steps=%0d", o_hit_steps);
            end else begin
                exp_col = expected_columns.pop_front();
                if (o_hit_steps !== exp_col.steps || o_ceiling_row !== exp_col.ceil_row
                    || o_floor_row !== exp_col.floor_row || o_shade !== exp_col.shade) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_col.steps, exp_col.ceil_row, exp_col.floor_row,
                                 exp_col.shade, o_hit_steps, o_ceiling_row, o_floor_row,
                                 o_shade);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
            if (o_valid && !i_stall && $urandom_range(0, 2) == 0)
                stall_left <= $urandom_range(0, 14);
        end
    end

    task automatic write_reg(input int idx, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 6'(idx * 8);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx < 4) wall_rows[idx] = value;
        else if (idx == REG_WIDTH) cur_width = value[7:0];
        else if (idx == REG_HEIGHT) cur_height = value[5:0];
    endtask

    task automatic drain();
        while (pending_rays.size() != 0 || i_valid || expected_columns.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_ray(input int c, input int r, input int hd, input int col);
        t_ray_req rq;
        rq.col = 4'(c);
        rq.row = 4'(r);
        rq.heading = 3'(hd);
        rq.column = 8'(col);
        pending_rays.push_back(rq);
    endtask

    task automatic load_map(input int mode);
        logic [63:0] w;
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0: w = 64'h0;
                1: w = 64'hFFFF_FFFF_FFFF_FFFF;
                default: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            write_reg(REG_MAP0 + i, w);
        end
    endtask

    task automatic random_phase(input int count, input int wmax);
        for (int i = 0; i < count; i++)
            add_ray($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, wmax));
        drain();
    endtask

    task automatic random_phase_fill();
        for (int i = 0; i < 8; i++)
            add_ray($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                    $urandom_range(0, 255));
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_player_col = 0;
        i_player_row = 0;
        i_heading = 0;
        i_column = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        cycles = 0;
        mismatches = 0;
        gap_left = 0;
        stall_left = 0;
        feed_hold = 0;
        in_taken = 0;
        for (int i = 0; i < 4; i++) wall_rows[i] = 0;
        cur_width = 120;
        cur_height = 40;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty map at reset registers, corners, every heading
        for (int hd = 0; hd < 8; hd++) add_ray(hd * 2, 15 - hd * 2, hd, hd * 17);
        add_ray(0, 0, 0, 0);
        add_ray(15, 15, 7, 119);
        add_ray(15, 0, 3, 200);
        drain();
        load_map(1);
        add_ray(7, 7, 2, 60);
        add_ray(0, 15, 5, 255);
        drain();
        // zero width, zero height, extremes
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        load_map(0);
        write_reg(REG_MAP2, 64'h0001_0000_0000_0080);
        add_ray(7, 4, 2, 254);
        add_ray(7, 4, 0, 0);
        add_ray(8, 8, 4, 5);
        drain();
        write_reg(REG_WIDTH, 255);
        write_reg(REG_HEIGHT, 63);
        add_ray(3, 3, 1, 254);
        add_ray(12, 9, 6, 128);
        drain();

        // sender holds until all results are back
        feed_hold = 1;
        random_phase_fill();
        while (expected_columns.size() != 0 || i_valid) @(posedge i_clk);
        feed_hold = 0;
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            int w;
            w = (ph == 0) ? 1 : (ph == 1) ? 255 : $urandom_range(1, 255);
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, (ph == 0) ? 1 : (ph == 1) ? 63 : $urandom_range(0, 63));
            load_map((ph == 3) ? 0 : (ph == 4) ? 1 : 2);
            random_phase(190, w);
        end

        if (mismatches == 0) $display("grid_raycast_column_tb: PASS");
        else $display("grid_raycast_column_tb: FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/grc_pkg.sv
rtl/grc_queue.sv
rtl/grc_front.sv
rtl/grc_back.sv
rtl/grid_raycast_column.sv
verif/grid_raycast_column_tb.sv
